/* rtl/shh_pkg.sv */
// Package: shared types, constants and helper functions of the half-step homing unit.
package shh_pkg;

	// Width of the step, budget and span counters.
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 2;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// Register indexes of the configuration port.
	localparam logic [IDX_BITS-1:0] REG_SEARCH_LIMIT  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_BACKOFF_STEPS = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_LOCKOUT_TICKS = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [15:0] SEARCH_LIMIT_RST  = 16'd10000;
	localparam logic [15:0] BACKOFF_STEPS_RST = 16'd10;
	localparam logic [7:0]  LOCKOUT_TICKS_RST = 8'd10;

	// Item opcodes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_HOME = 1'b1;

	// Direction codes, two's complement.
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd3;

	// Position marks in degrees.
	localparam logic [7:0] POS_LEFT   = 8'd0;
	localparam logic [7:0] POS_CENTRE = 8'd90;
	localparam logic [7:0] POS_RIGHT  = 8'd180;

	localparam logic [1:0] HITS_MAX = 2'd3;

	typedef struct packed {
		logic [15:0] search_limit;
		logic [15:0] backoff_steps;
		logic [7:0]  lockout_ticks;
	} shh_cfg_t;

	typedef struct packed {
		logic [3:0] coil_pattern;
		logic [7:0] position_deg;
		logic [1:0] hits_seen;
		logic       stepped;
		logic       limit_taken;
	} shh_res_t;

	// Half-step coil drive table.
	function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
		logic [3:0] pat;
		case (phase)
			3'd0:    pat = 4'd8;
			3'd1:    pat = 4'd10;
			3'd2:    pat = 4'd2;
			3'd3:    pat = 4'd6;
			3'd4:    pat = 4'd4;
			3'd5:    pat = 4'd5;
			3'd6:    pat = 4'd1;
			3'd7:    pat = 4'd9;
			default: pat = 4'd0;
		endcase
		return pat;
	endfunction

	// Load a 16-bit register value into a counter, saturating if the counter is narrower.
	function automatic logic [COUNT_BITS-1:0] cnt_load(input logic [15:0] v);
		logic [31:0] ext;
		ext = 32'(v);
		return (ext > 32'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(ext);
	endfunction

	// Saturating increment.
	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

/* rtl/shh_cmd_if.sv */
// Interface: command channel carrying ticks and homing requests.
interface shh_cmd_if;
	logic valid;
	logic ready;
	logic op;
	logic limit_left;
	logic limit_right;

	modport source (output valid, output op, output limit_left, output limit_right,
		input ready);
	modport sink (input valid, input op, input limit_left, input limit_right,
		output ready);
endinterface

/* rtl/shh_res_if.sv */
// Interface: result channel carrying coil pattern and homing status.
interface shh_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] coil_pattern;
	logic [7:0] position_deg;
	logic [1:0] hits_seen;
	logic       stepped;
	logic       limit_taken;

	modport source (output valid, output coil_pattern, output position_deg,
		output hits_seen, output stepped, output limit_taken, input ready);
	modport sink (input valid, input coil_pattern, input position_deg,
		input hits_seen, input stepped, input limit_taken, output ready);
endinterface

/* rtl/stepper_half_step_homing_unit.sv */
// Top level: half-step stepper sequencer with limit-switch homing.
// Each transfer on cmd is a timer tick (op 0, with both limit switches) or a
// start-homing request (op 1), and it yields exactly one transfer on res with
// the latched coil pattern, the position mark, the saturating hit count and
// flags for a step taken or a limit hit handled. An item is held in the input
// register and then updates the homing state, writing its result register at
// the same edge. A new item is taken every cycle while the result side does not
// stall; the single state update per item sets that rate.
// The result register decouples the two sides: cmd stays ready while a result
// waits as long as the input register can move on. Write the configuration
// registers (search limit, back-off count, lockout ticks) only while no item
// is in flight.
module stepper_half_step_homing_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [shh_pkg::IDX_BITS-1:0] cfg_idx,
	input  logic [shh_pkg::CFG_BITS-1:0] cfg_data,
	shh_cmd_if.sink                      cmd,
	shh_res_if.source                    res
);

	shh_pkg::shh_cfg_t cfg;
	shh_pkg::shh_res_t core_res;
	shh_pkg::shh_res_t res_q;

	logic vld_s1;
	logic op_s1, left_s1, right_s1;
	logic res_vld_q;
	logic advance;
	logic fire;

	shh_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Result slot is free when empty or being drained this cycle.
	assign advance   = !res_vld_q || res.ready;
	// Input register hands its item to the state logic.
	assign fire      = vld_s1 && advance;
	assign cmd.ready = !vld_s1 || advance;

	// Input register: hold the item until the state logic takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1    <= cmd.op;
			left_s1  <= cmd.limit_left;
			right_s1 <= cmd.limit_right;
		end
	end

	shh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.op          (op_s1),
		.limit_left  (left_s1),
		.limit_right (right_s1),
		.cfg         (cfg),
		.res         (core_res)
	);

	// Result register: capture on fire, drop on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= core_res;
		end
	end

	assign res.valid        = res_vld_q;
	assign res.coil_pattern = res_q.coil_pattern;
	assign res.position_deg = res_q.position_deg;
	assign res.hits_seen    = res_q.hits_seen;
	assign res.stepped      = res_q.stepped;
	assign res.limit_taken  = res_q.limit_taken;

endmodule

/* rtl/shh_cfg.sv */
// Configuration register file of the half-step homing unit.
module shh_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [shh_pkg::IDX_BITS-1:0] cfg_idx,
	input  logic [shh_pkg::CFG_BITS-1:0] cfg_data,
	output shh_pkg::shh_cfg_t            cfg
);

	shh_pkg::shh_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.search_limit  <= shh_pkg::SEARCH_LIMIT_RST;
			cfg_q.backoff_steps <= shh_pkg::BACKOFF_STEPS_RST;
			cfg_q.lockout_ticks <= shh_pkg::LOCKOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				shh_pkg::REG_SEARCH_LIMIT:  cfg_q.search_limit  <= cfg_data;
				shh_pkg::REG_BACKOFF_STEPS: cfg_q.backoff_steps <= cfg_data;
				shh_pkg::REG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/shh_core.sv */
// Homing state and single-pass next-state logic for one item.
module shh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              op,
	input  logic              limit_left,
	input  logic              limit_right,
	input  shh_pkg::shh_cfg_t cfg,
	output shh_pkg::shh_res_t res
);

	logic [2:0]                     phase_q, phase_d;
	logic [1:0]                     dir_q, dir_d;
	logic [shh_pkg::COUNT_BITS-1:0] steps_q, steps_d;
	logic [shh_pkg::COUNT_BITS-1:0] budget_q, budget_d;
	logic [shh_pkg::COUNT_BITS-1:0] span_q, span_d;
	logic [7:0]                     lockout_q, lockout_d;
	logic [1:0]                     hits_q, hits_d;
	logic [7:0]                     pos_q, pos_d;
	logic [3:0]                     coil_q, coil_d;
	logic                           stepped, taken;
	logic                           active, hit, moving;

	always_comb begin
		phase_d   = phase_q;
		dir_d     = dir_q;
		steps_d   = steps_q;
		budget_d  = budget_q;
		span_d    = span_q;
		lockout_d = lockout_q;
		hits_d    = hits_q;
		pos_d     = pos_q;
		coil_d    = coil_q;
		stepped   = 1'b0;
		taken     = 1'b0;
		active    = (op == shh_pkg::OP_TICK) && (steps_q <= budget_q);
		hit       = (limit_left || limit_right) && (lockout_q == 8'd0);
		moving    = (dir_q == shh_pkg::DIR_FWD) || (dir_q == shh_pkg::DIR_REV);

		if (op == shh_pkg::OP_HOME) begin
			budget_d = shh_pkg::cnt_load(cfg.search_limit);
			dir_d    = shh_pkg::DIR_FWD;
			span_d   = '0;
		end else if (active && hit) begin
			taken     = 1'b1;
			dir_d     = 2'd0 - dir_q;
			steps_d   = '0;
			lockout_d = cfg.lockout_ticks;
			hits_d    = (hits_q == shh_pkg::HITS_MAX) ? hits_q : hits_q + 2'd1;
			if (dir_q == shh_pkg::DIR_FWD) begin
				pos_d = shh_pkg::POS_RIGHT;
			end else if (dir_q == shh_pkg::DIR_REV) begin
				pos_d = shh_pkg::POS_LEFT;
			end
			// Budget follows the new hit count: restart search, centre, or back off.
			case (hits_d)
				2'd1: budget_d = shh_pkg::cnt_load(cfg.search_limit);
				2'd2: begin
					budget_d = span_q >> 1;
					pos_d    = shh_pkg::POS_CENTRE;
				end
				default: budget_d = shh_pkg::cnt_load(cfg.backoff_steps);
			endcase
		end else if (active) begin
			stepped = 1'b1;
			if (dir_q == shh_pkg::DIR_FWD) begin
				phase_d = phase_q + 3'd1;
			end else if (dir_q == shh_pkg::DIR_REV) begin
				phase_d = phase_q - 3'd1;
			end
			coil_d = shh_pkg::coil_lookup(phase_d);
			if (moving) begin
				steps_d = shh_pkg::cnt_inc(steps_q);
			end
			if (lockout_q != 8'd0) begin
				lockout_d = lockout_q - 8'd1;
			end
			if (hits_q == 2'd1) begin
				span_d = shh_pkg::cnt_inc(span_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			dir_q     <= shh_pkg::DIR_STOP;
			steps_q   <= '0;
			budget_q  <= '0;
			span_q    <= '0;
			lockout_q <= '0;
			hits_q    <= '0;
			pos_q     <= '0;
			coil_q    <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			dir_q     <= dir_d;
			steps_q   <= steps_d;
			budget_q  <= budget_d;
			span_q    <= span_d;
			lockout_q <= lockout_d;
			hits_q    <= hits_d;
			pos_q     <= pos_d;
			coil_q    <= coil_d;
		end
	end

	assign res.coil_pattern = coil_d;
	assign res.position_deg = pos_d;
	assign res.hits_seen    = hits_d;
	assign res.stepped      = stepped;
	assign res.limit_taken  = taken;

	a_dir_legal: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q != 2'd2)
		else $error("direction register holds the unused code");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hits_q >= $past(hits_q))
		else $error("hit count went down");

	a_lockout_reload: assert property (@(posedge clk) disable iff (!arst_n)
		fire && taken |=> lockout_q == $past(cfg.lockout_ticks) && steps_q == '0)
		else $error("limit hit did not reload lockout and clear steps");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(steps_q) && $stable(span_q))
		else $error("state moved without an item");

endmodule

/* tb/tb_stepper_half_step_homing_unit.sv */
// Testbench: self-checking bench of the half-step homing unit with a built-in behavioural predictor.
`timescale 1ns / 100ps

module tb_stepper_half_step_homing_unit;

	// Hard stop for a hung run: far beyond the slowest legal run.
	localparam int unsigned RUN_LIMIT_NS = 3_000_000;

	// Coil drive bits per half-step phase, phase 0 in the lowest nibble.
	localparam logic [7:0][3:0] HALF_STEP_COILS = {4'd9, 4'd1, 4'd5, 4'd4, 4'd6, 4'd2, 4'd10, 4'd8};

	typedef struct packed {
		logic op;
		logic left;
		logic right;
	} motion_cmd_t;

	// Receiver behaviour, re-chosen whenever its countdown runs out.
	typedef enum logic [1:0] {
		RX_FLOW,
		RX_MOSTLY,
		RX_SPARSE,
		RX_HOLD
	} rx_mode_e;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [shh_pkg::IDX_BITS-1:0] cfg_idx;
	logic [shh_pkg::CFG_BITS-1:0] cfg_data;

	shh_cmd_if cmd_ch ();
	shh_res_if res_ch ();

	stepper_half_step_homing_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	always #5 clk = ~clk;

	// Items waiting to be driven, and results the block still owes us.
	motion_cmd_t       pending_moves[$];
	shh_pkg::shh_res_t expected_results[$];

	// Register values as the block should hold them.
	shh_pkg::shh_cfg_t cfg_model;

	// Predicted homing state.
	logic [2:0]                     mot_phase;
	logic [1:0]                     mot_dir;
	logic [shh_pkg::COUNT_BITS-1:0] mot_steps;
	logic [shh_pkg::COUNT_BITS-1:0] mot_budget;
	logic [shh_pkg::COUNT_BITS-1:0] mot_span;
	logic [7:0]                     mot_lock;
	logic [1:0]                     mot_hits;
	logic [7:0]                     mot_pos;
	logic [3:0]                     mot_coil;

	int  mismatches = 0;
	int  results_seen = 0;
	bit  cmd_xfer = 1'b0;
	int  burst_left = 0;
	int  gap_left = 0;
	rx_mode_e rx_mode = RX_FLOW;
	int  rx_left = 0;

	// Clamp a register value into a counter that may be narrower than the register.
	function automatic logic [shh_pkg::COUNT_BITS-1:0] clamp_count(input logic [15:0] v);
		return (32'(v) > 32'({shh_pkg::COUNT_BITS{1'b1}})) ? {shh_pkg::COUNT_BITS{1'b1}} :
			shh_pkg::COUNT_BITS'(v);
	endfunction

	// Advance the predicted state by one accepted item and queue the result it owes.
	function automatic void predict_motion(input logic op, input logic left, input logic right);
		shh_pkg::shh_res_t want;
		want = '0;
		if (op == shh_pkg::OP_HOME) begin
			// Homing restarts the search but keeps the step count, hits and mark.
			mot_budget = clamp_count(cfg_model.search_limit);
			mot_dir    = shh_pkg::DIR_FWD;
			mot_span   = '0;
		end else if (mot_steps <= mot_budget) begin
			if ((left || right) && mot_lock == 8'd0) begin
				want.limit_taken = 1'b1;
				// A stopped motor keeps its mark and stays stopped.
				if (mot_dir == shh_pkg::DIR_FWD) begin
					mot_pos = shh_pkg::POS_RIGHT;
				end else if (mot_dir == shh_pkg::DIR_REV) begin
					mot_pos = shh_pkg::POS_LEFT;
				end
				mot_dir    = 2'(2'd0 - mot_dir);
				mot_steps  = '0;
				mot_budget = clamp_count(cfg_model.backoff_steps);
				mot_lock   = cfg_model.lockout_ticks;
				if (mot_hits != shh_pkg::HITS_MAX) begin
					mot_hits = mot_hits + 2'd1;
				end
				if (mot_hits == 2'd1) begin
					mot_budget = clamp_count(cfg_model.search_limit);
				end else if (mot_hits == 2'd2) begin
					// Second limit: head back to the middle of the measured span.
					mot_budget = mot_span >> 1;
					mot_pos    = shh_pkg::POS_CENTRE;
				end
			end else begin
				want.stepped = 1'b1;
				if (mot_dir == shh_pkg::DIR_FWD) begin
					mot_phase = mot_phase + 3'd1;
				end else if (mot_dir == shh_pkg::DIR_REV) begin
					mot_phase = mot_phase - 3'd1;
				end
				// The latch reloads even when stopped.
				mot_coil = HALF_STEP_COILS[mot_phase];
				if ((mot_dir == shh_pkg::DIR_FWD || mot_dir == shh_pkg::DIR_REV) &&
						mot_steps != {shh_pkg::COUNT_BITS{1'b1}}) begin
					mot_steps = mot_steps + 1'b1;
				end
				if (mot_lock != 8'd0) begin
					mot_lock = mot_lock - 8'd1;
				end
				if (mot_hits == 2'd1 && mot_span != {shh_pkg::COUNT_BITS{1'b1}}) begin
					mot_span = mot_span + 1'b1;
				end
			end
		end
		// Budget spent: the tick changes nothing and the result just reports state.
		want.coil_pattern = mot_coil;
		want.position_deg = mot_pos;
		want.hits_seen    = mot_hits;
		expected_results.push_back(want);
	endfunction

	function automatic void add_move(input logic op, input logic left, input logic right);
		pending_moves.push_back('{op: op, left: left, right: right});
	endfunction

	// Queue homing runs with random content: home, a few searches ending on a switch,
	// then some drift that often runs the back-off budget dry. Mix in some noise.
	task automatic queue_homing_runs(input int quota);
		int queued;
		int hits;
		int run;
		int press;
		queued = 0;
		while (queued < quota) begin
			if ($urandom_range(0, 99) < 12) begin
				add_move(1'($urandom), 1'($urandom), 1'($urandom));
				queued++;
			end else begin
				add_move(shh_pkg::OP_HOME, 1'($urandom), 1'($urandom));
				queued++;
				hits = $urandom_range(1, 4);
				repeat (hits) begin
					run = $urandom_range(0, int'(cfg_model.lockout_ticks) + 6);
					repeat (run) begin
						// Now and then press a switch early, inside the lockout.
						if ($urandom_range(0, 9) == 0) begin
							add_move(shh_pkg::OP_TICK, 1'($urandom), 1'($urandom));
						end else begin
							add_move(shh_pkg::OP_TICK, 1'b0, 1'b0);
						end
						queued++;
					end
					press = $urandom_range(1, 3);
					add_move(shh_pkg::OP_TICK, press[0], press[1]);
					queued++;
				end
				run = $urandom_range(0, 12);
				repeat (run) begin
					add_move(shh_pkg::OP_TICK, 1'b0, 1'b0);
					queued++;
				end
			end
		end
	endtask

	// Hold until every item has gone in and every result has come out, then let
	// the pipeline drain before touching the registers.
	task automatic settle_block();
		do begin
			@(negedge clk);
		end while (pending_moves.size() != 0 || cmd_ch.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Write all three registers on consecutive cycles, then drop the enable.
	task automatic load_settings(input logic [15:0] search, input logic [15:0] backoff,
			input logic [15:0] lockout_word);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= shh_pkg::REG_SEARCH_LIMIT;
		cfg_data <= search;
		@(negedge clk);
		cfg_idx  <= shh_pkg::REG_BACKOFF_STEPS;
		cfg_data <= backoff;
		@(negedge clk);
		cfg_idx  <= shh_pkg::REG_LOCKOUT_TICKS;
		cfg_data <= lockout_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_model.search_limit  = search;
		cfg_model.backoff_steps = backoff;
		cfg_model.lockout_ticks = lockout_word[7:0];
	endtask

	// Command driver: present items in bursts with random gaps, and hold each one
	// until its transfer has happened.
	always @(negedge clk) begin
		motion_cmd_t nxt;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (!cmd_ch.valid || cmd_xfer) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_moves.size() != 0) begin
				nxt = pending_moves.pop_front();
				cmd_ch.valid       <= 1'b1;
				cmd_ch.op          <= nxt.op;
				cmd_ch.limit_left  <= nxt.left;
				cmd_ch.limit_right <= nxt.right;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// New burst; a third of them follow straight on with no gap.
					burst_left = $urandom_range(0, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: flowing, mostly ready, mostly stalled, or one long hold.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(4, 40);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_FLOW:   res_ch.ready <= 1'b1;
				RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   res_ch.ready <= (rx_left == 0);
			endcase
		end
	end

	// Monitor: check each result transfer against the oldest prediction first,
	// then predict for a command transfer at the same edge.
	always @(posedge clk) begin
		shh_pkg::shh_res_t got;
		shh_pkg::shh_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.coil_pattern = res_ch.coil_pattern;
			got.position_deg = res_ch.position_deg;
			got.hits_seen    = res_ch.hits_seen;
			got.stepped      = res_ch.stepped;
			got.limit_taken  = res_ch.limit_taken;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result %0d arrived with nothing expected", $realtime,
						results_seen);
				end
			end else begin
				want = expected_results.pop_front();
				if (got.coil_pattern !== want.coil_pattern ||
						got.position_deg !== want.position_deg ||
						got.hits_seen !== want.hits_seen ||
						got.stepped !== want.stepped ||
						got.limit_taken !== want.limit_taken) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result %0d: expected coil %h pos %0d hits %0d step %b ",
							$realtime, results_seen, want.coil_pattern, want.position_deg,
							want.hits_seen, want.stepped,
							"limit %b, got coil %h pos %0d hits %0d step %b limit %b",
							want.limit_taken, got.coil_pattern, got.position_deg,
							got.hits_seen, got.stepped, got.limit_taken);
					end
				end
			end
			results_seen++;
		end
		cmd_xfer = arst_n && cmd_ch.valid && cmd_ch.ready;
		if (cmd_xfer) begin
			predict_motion(cmd_ch.op, cmd_ch.limit_left, cmd_ch.limit_right);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = shh_pkg::REG_SEARCH_LIMIT;
		cfg_data           = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.op          = shh_pkg::OP_TICK;
		cmd_ch.limit_left  = 1'b0;
		cmd_ch.limit_right = 1'b0;
		res_ch.ready       = 1'b0;
		cfg_model.search_limit  = shh_pkg::SEARCH_LIMIT_RST;
		cfg_model.backoff_steps = shh_pkg::BACKOFF_STEPS_RST;
		cfg_model.lockout_ticks = shh_pkg::LOCKOUT_TICKS_RST;
		mot_phase  = '0;
		mot_dir    = shh_pkg::DIR_STOP;
		mot_steps  = '0;
		mot_budget = '0;
		mot_span   = '0;
		mot_lock   = '0;
		mot_hits   = '0;
		mot_pos    = shh_pkg::POS_LEFT;
		mot_coil   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed walk on reset settings: a tick and a hit while stopped, a
		// press ignored under lockout, then a full search.
		add_move(shh_pkg::OP_TICK, 1'b0, 1'b0);
		add_move(shh_pkg::OP_TICK, 1'b1, 1'b0);
		add_move(shh_pkg::OP_TICK, 1'b1, 1'b1);
		add_move(shh_pkg::OP_HOME, 1'b0, 1'b0);
		// Nine steps wear the lockout down while switches bounce; they also set the span.
		for (int k = 0; k < 9; k++) begin
			add_move(shh_pkg::OP_TICK, k[0], k[1]);
		end
		// Second hit: mark the centre and head back half the span.
		add_move(shh_pkg::OP_TICK, 1'b0, 1'b1);
		repeat (5) add_move(shh_pkg::OP_TICK, 1'b0, 1'b0);
		// Budget spent: both ticks change nothing, switches included.
		add_move(shh_pkg::OP_TICK, 1'b0, 1'b0);
		add_move(shh_pkg::OP_TICK, 1'b1, 1'b1);
		// Re-home, step out the rest of the lockout, and take a third hit.
		add_move(shh_pkg::OP_HOME, 1'b1, 1'b1);
		add_move(shh_pkg::OP_TICK, 1'b1, 1'b0);
		repeat (4) add_move(shh_pkg::OP_TICK, 1'b0, 1'b0);
		add_move(shh_pkg::OP_TICK, 1'b0, 1'b1);
		settle_block();

		// Everything at zero: empty budgets and no lockout.
		load_settings(16'h0000, 16'h0000, 16'h0000);
		queue_homing_runs(80);
		settle_block();

		// Small budgets so back-off runs dry; junk in the upper lockout byte.
		repeat (6) begin
			load_settings(16'($urandom_range(20, 96)), 16'($urandom_range(0, 12)),
				{8'($urandom), 8'($urandom_range(0, 6))});
			queue_homing_runs(110);
			settle_block();
		end

		// Everything at its top value.
		load_settings(16'hFFFF, 16'hFFFF, 16'h00FF);
		queue_homing_runs(120);
		settle_block();

		// Keep watching a little longer for a stray result.
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
